// ----- src/pflm_pkg.sv -----
// Package for the page frame LRU manager.
// Holds the request codes, fixed field widths and the sequencer state type.
// No dependencies.
`default_nettype none

package pflm_pkg;

   localparam int OP_W   = 2;
   localparam int PROC_W = 5;
   localparam int PAGE_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TERM  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ----- src/page_frame_lru_manager_top.sv -----
// Page frame LRU manager: fully associative frame table with a one-frame-per-cycle
// scan sequencer. Depends on pflm_pkg for request codes and the state type.
// The frame table is held in flip-flops inside this module.
`default_nettype none

// The result of a request transfer on req_ is offered on rsp_ once the request has passed
// the idle state, in which it is captured, the scan state, in which the shared tag compare
// and age compare unit walks the table one frame per cycle, and the update state, in which
// the chosen frame and the ages are updated once no earlier result is held on rsp_.
// The block takes no new request while the scan or the update runs;
// a result may wait on rsp_ while the next request is captured, but that request is
// not finished until the waiting result has been taken. Ages stay a permutation of
// 0..FRAMES-1, age 0 being the most recently used frame.
module page_frame_lru_manager_top #(
   parameter int FRAMES = 8,
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int CNT_W = $clog2(FRAMES + 1),
   localparam int REQ_BITS = pflm_pkg::OP_W + pflm_pkg::PROC_W + pflm_pkg::PAGE_W,
   localparam int REQ_W = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = 3 + IDX_W + pflm_pkg::PROC_W + pflm_pkg::PAGE_W + CNT_W,
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: op, process_slot, page, zero fill.
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // Fields from bit 0: hit, frame_index, write_back, evicted_valid,
   // evicted_process, evicted_page, freed_count, zero fill.
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int PROC_W = pflm_pkg::PROC_W;
   localparam int PAGE_W = pflm_pkg::PAGE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

   // Frame table
   logic              valid_ff [FRAMES];
   logic              dirty_ff [FRAMES];
   logic [PROC_W-1:0] owner_ff [FRAMES];
   logic [PAGE_W-1:0] page_ff  [FRAMES];
   logic [IDX_W-1:0]  age_ff   [FRAMES];
   logic              valid_in [FRAMES];
   logic              dirty_in [FRAMES];
   logic [PROC_W-1:0] owner_in [FRAMES];
   logic [PAGE_W-1:0] page_in  [FRAMES];
   logic [IDX_W-1:0]  age_in   [FRAMES];

   pflm_pkg::state_type state_ff, state_in;

   // Captured request
   pflm_pkg::op_type  op_ff, op_in;
   logic [PROC_W-1:0] proc_ff, proc_in;
   logic [PAGE_W-1:0] pg_ff, pg_in;

   // Scan accumulators
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]  hit_age_ff, hit_age_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  free_age_ff, free_age_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]  best_age_ff, best_age_in;
   logic              vic_dirty_ff, vic_dirty_in;
   logic [PROC_W-1:0] vic_owner_ff, vic_owner_in;
   logic [PAGE_W-1:0] vic_page_ff, vic_page_in;
   logic [CNT_W-1:0]  freed_ff, freed_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // Shared compare unit on the frame under scan
   logic              owner_eq;
   logic              tag_eq;
   logic              req_fire;
   logic              out_free;

   // Update step
   logic [IDX_W-1:0]  tgt_idx;
   logic [IDX_W-1:0]  tgt_age;
   logic              is_req;
   logic              is_evict;
   logic              res_hit;
   logic [IDX_W-1:0]  res_idx;
   logic              res_wb;
   logic              res_ev;
   logic [PROC_W-1:0] res_proc;
   logic [PAGE_W-1:0] res_page;
   logic [CNT_W-1:0]  res_freed;

   assign owner_eq = valid_ff[scan_ff] && (owner_ff[scan_ff] == proc_ff);
   assign tag_eq   = owner_eq && (page_ff[scan_ff] == pg_ff);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_req   = (op_ff == pflm_pkg::OP_READ) || (op_ff == pflm_pkg::OP_WRITE);
   assign is_evict = is_req && !hit_found_ff && !free_found_ff;

   assign req_tready = (state_ff == pflm_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (hit_found_ff) begin
         tgt_idx = hit_idx_ff;
         tgt_age = hit_age_ff;
      end else if (free_found_ff) begin
         tgt_idx = free_idx_ff;
         tgt_age = free_age_ff;
      end else begin
         tgt_idx = best_idx_ff;
         tgt_age = best_age_ff;
      end
   end

   always_comb begin
      res_hit   = 1'b0;
      res_idx   = '0;
      res_wb    = 1'b0;
      res_ev    = 1'b0;
      res_proc  = '0;
      res_page  = '0;
      res_freed = '0;
      if (op_ff == pflm_pkg::OP_TERM) begin
         res_freed = freed_ff;
      end else if (is_req) begin
         res_hit = hit_found_ff;
         res_idx = tgt_idx;
         if (is_evict) begin
            res_wb   = vic_dirty_ff;
            res_ev   = 1'b1;
            res_proc = vic_owner_ff;
            res_page = vic_page_ff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      proc_in       = proc_ff;
      pg_in         = pg_ff;
      scan_in       = scan_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_age_in    = hit_age_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      free_age_in   = free_age_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      vic_dirty_in  = vic_dirty_ff;
      vic_owner_in  = vic_owner_ff;
      vic_page_in   = vic_page_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      for (int i = 0; i < FRAMES; i++) begin
         valid_in[i] = valid_ff[i];
         dirty_in[i] = dirty_ff[i];
         owner_in[i] = owner_ff[i];
         page_in[i]  = page_ff[i];
         age_in[i]   = age_ff[i];
      end

      case (state_ff)
         pflm_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in         = pflm_pkg::op_type'(req_tdata[pflm_pkg::OP_W-1:0]);
               proc_in       = req_tdata[pflm_pkg::OP_W +: PROC_W];
               pg_in         = req_tdata[pflm_pkg::OP_W + PROC_W +: PAGE_W];
               scan_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               freed_in      = '0;
               state_in      = pflm_pkg::ST_SCAN;
            end
         end
         pflm_pkg::ST_SCAN: begin
            if (op_ff == pflm_pkg::OP_TERM) begin
               if (owner_eq) begin
                  valid_in[scan_ff] = 1'b0;
                  dirty_in[scan_ff] = 1'b0;
                  owner_in[scan_ff] = '0;
                  page_in[scan_ff]  = '0;
                  freed_in          = freed_ff + CNT_W'(1);
               end
            end else begin
               if (tag_eq && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = scan_ff;
                  hit_age_in   = age_ff[scan_ff];
               end
               if (!valid_ff[scan_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = scan_ff;
                  free_age_in   = age_ff[scan_ff];
               end
               // Frame 0 is the default victim; later frames win only on a strictly
               // greater age, so ties go to the lowest-numbered frame.
               if (scan_ff == '0 || age_ff[scan_ff] > best_age_ff) begin
                  best_idx_in  = scan_ff;
                  best_age_in  = age_ff[scan_ff];
                  vic_dirty_in = dirty_ff[scan_ff];
                  vic_owner_in = owner_ff[scan_ff];
                  vic_page_in  = page_ff[scan_ff];
               end
            end
            if (scan_ff == LAST_IDX) begin
               state_in = pflm_pkg::ST_UPDATE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         pflm_pkg::ST_UPDATE: begin
            if (out_free) begin
               if (is_req) begin
                  // Every frame younger than the target ages by one.
                  for (int i = 0; i < FRAMES; i++) begin
                     if (age_ff[i] < tgt_age) begin
                        age_in[i] = age_ff[i] + IDX_W'(1);
                     end
                  end
                  age_in[tgt_idx] = '0;
                  if (hit_found_ff) begin
                     if (op_ff == pflm_pkg::OP_WRITE) begin
                        dirty_in[tgt_idx] = 1'b1;
                     end
                  end else begin
                     valid_in[tgt_idx] = 1'b1;
                     dirty_in[tgt_idx] = (op_ff == pflm_pkg::OP_WRITE);
                     owner_in[tgt_idx] = proc_ff;
                     page_in[tgt_idx]  = pg_ff;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({res_freed, res_page, res_proc, res_ev, res_wb,
                                      res_idx, res_hit});
               state_in     = pflm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pflm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pflm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            owner_ff[i] <= '0;
            page_ff[i]  <= '0;
            age_ff[i]   <= IDX_W'(i);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= valid_in[i];
            dirty_ff[i] <= dirty_in[i];
            owner_ff[i] <= owner_in[i];
            page_ff[i]  <= page_in[i];
            age_ff[i]   <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      proc_ff       <= proc_in;
      pg_ff         <= pg_in;
      scan_ff       <= scan_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_age_ff    <= hit_age_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      free_age_ff   <= free_age_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      vic_dirty_ff  <= vic_dirty_in;
      vic_owner_ff  <= vic_owner_in;
      vic_page_ff   <= vic_page_in;
      freed_ff      <= freed_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Checks
   logic [FRAMES-1:0] age_zero;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         age_zero[i] = (age_ff[i] == '0);
      end
   end

   // The ages form a permutation, so exactly one frame is the most recent.
   a_one_newest: assert property (@(posedge clock) disable iff (reset)
      $onehot(age_zero))
      else $error("LRU ages lost their permutation");

   // A write-back is only reported together with an eviction.
   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff[1 + IDX_W] || rsp_data_ff[2 + IDX_W]))
      else $error("write-back reported without an eviction");

   // A hit never evicts anything.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> !rsp_data_ff[2 + IDX_W])
      else $error("hit reported with an eviction");

   // A request transfer is followed by the scan state starting at frame 0.
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == pflm_pkg::ST_SCAN) && (scan_ff == '0))
      else $error("scan did not start at frame 0");

endmodule

`default_nettype wire
